// ===== src/mft_pkg.sv =====
package mft_pkg;

  // character codes the scanner looks for
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  // token kinds
  localparam logic [1:0] KIND_WORD    = 2'd0;
  localparam logic [1:0] KIND_PUNCT   = 2'd1;
  localparam logic [1:0] KIND_QUOTED  = 2'd2;
  localparam logic [1:0] KIND_TEXTURE = 2'd3;

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // bytes of look-ahead the scanner examines at one arrival
  localparam int PEEK_BYTES = 5;
  // most characters one arrival can push
  localparam int ARRIVE_MAX = 5;
  // cap on characters per transaction
  localparam logic [3:0] MAX_RESULTS = 4'd8;

  // output queue
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  tok_char;
    logic        first;
    logic        last;
    logic [1:0]  kind;
    logic        empty;
    logic [23:0] line;
  } tok_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c <= CH_SPACE) || c[7];
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_SQUOTE) || (c == CH_COLON);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return is_ws(c) || is_punct(c);
  endfunction

endpackage

// ===== src/map_file_tokenizer.sv =====
// channel  handshake                 payload                                              dir
// byte     byte_valid, byte_stall    data_byte, end_of_file                               in
// token    token_valid, token_stall  token_char/first/last/kind, empty_quoted, line_number out
//
// one byte transaction per cycle while the output queue has room for five
// characters; each byte makes at most one arrival, which pushes up to five
// characters (a texture comment) into a 16-entry queue that drains one per cycle while
// token_stall is low; an end-of-file transaction drains the window one arrival a cycle
// while the queue has room, and byte_stall stays high meanwhile
// rst is synchronous and returns the scanner to line one with an empty window
// token_stall only holds the queue head; byte_stall follows the queue fill
module map_file_tokenizer import mft_pkg::*; #(
  parameter int WINDOW_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [7:0]  token_char,
  output logic        token_first,
  output logic        token_last,
  output logic [1:0]  token_kind,
  output logic        empty_quoted,
  output logic [23:0] line_number
);

  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_BYTES - 1);
  localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QUEUE_DEPTH - ARRIVE_MAX);

  typedef enum logic {ST_RUN, ST_DRAIN} ctl_state_t;
  typedef enum logic [1:0] {
    MODE_BETWEEN, MODE_COMMENT, MODE_WORD, MODE_QUOTE
  } scan_mode_t;

  // scanner state
  ctl_state_t        state;
  scan_mode_t        scan_mode;
  logic              token_open;
  logic [23:0]       line_count;
  logic [7:0]        win [WINDOW_BYTES];
  logic [FILL_W-1:0] fill;
  logic              drain_first;   // partial window arrives once before shifting
  logic [3:0]        emitted;       // characters pushed for the end-of-file transaction

  // output queue
  tok_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic room, run_acc, run_arrive, drain_step, drain_arrive, arrive, pop;
  logic fill_full;

  // window after taking the new byte, and window shifted by one for draining
  logic [7:0] w_new   [WINDOW_BYTES];
  logic [7:0] shifted [WINDOW_BYTES];

  // arrival unit
  logic [7:0]        a_src [PEEK_BYTES];
  logic [7:0]        pk    [PEEK_BYTES];
  logic [FILL_W-1:0] a_nvalid;
  logic [7:0]        c;
  logic              ends;
  logic [23:0]       line_next;
  scan_mode_t        mode_next;
  logic              open_next;
  tok_t              em [ARRIVE_MAX];
  logic [2:0]        em_cnt;
  logic [3:0]        allowed;
  logic [3:0]        wr_n;

  assign room       = (count <= ROOM_LIMIT);
  assign byte_stall = (state == ST_DRAIN) || !room;
  assign run_acc    = byte_valid && !byte_stall;
  assign fill_full  = (fill == FILL_FULL);
  assign run_arrive = run_acc && !end_of_file && (fill_full || fill == FILL_LAST);
  assign drain_step = (state == ST_DRAIN) && room;
  assign drain_arrive = drain_step && (drain_first || fill > FILL_W'(1));
  assign arrive     = run_arrive || drain_arrive;

  assign token_valid = (count != '0);
  assign pop         = token_valid && !token_stall;

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      if (fill_full) begin
        w_new[i] = (i == WINDOW_BYTES - 1) ? data_byte : shifted[i];
      end else begin
        w_new[i] = (fill == FILL_W'(i)) ? data_byte : win[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      shifted[i] = win[i + 1];
    end
    shifted[WINDOW_BYTES-1] = 8'h00;
  end

  // source of the arrival: fresh window while running, stored or shifted
  // window while draining
  always_comb begin
    for (int i = 0; i < PEEK_BYTES; i++) begin
      if (state == ST_RUN) begin
        a_src[i] = w_new[i];
      end else if (drain_first) begin
        a_src[i] = win[i];
      end else begin
        a_src[i] = shifted[i];
      end
    end
    if (state == ST_RUN) begin
      a_nvalid = FILL_FULL;
    end else if (drain_first) begin
      a_nvalid = fill;
    end else begin
      a_nvalid = fill - FILL_W'(1);
    end
    for (int i = 0; i < PEEK_BYTES; i++) begin
      pk[i] = (FILL_W'(i) < a_nvalid) ? a_src[i] : 8'h00;
    end
  end

  // one arrival: the oldest byte is examined against up to four bytes ahead
  always_comb begin
    c = a_src[0];
    line_next = ((c == CH_LF) && (line_count != LINE_MAX)) ? line_count + 24'd1 : line_count;
    ends = (a_nvalid < FILL_W'(2)) || is_sep(pk[1]);
    mode_next = scan_mode;
    open_next = token_open;
    em_cnt = 3'd0;
    for (int k = 0; k < ARRIVE_MAX; k++) begin
      em[k] = '0;
    end

    case (scan_mode)
      MODE_COMMENT: begin
        if (c == CH_LF) begin
          mode_next = MODE_BETWEEN;
        end
      end
      MODE_QUOTE: begin
        if (c == CH_DQUOTE) begin
          if (!token_open) begin
            em[0] = '{tok_char: 8'h00, first: 1'b1, last: 1'b1, kind: KIND_QUOTED,
                      empty: 1'b1, line: line_next};
            em_cnt = 3'd1;
          end
          open_next = 1'b0;
          mode_next = MODE_BETWEEN;
        end else begin
          em[0] = '{tok_char: c, first: !token_open,
                    last: (a_nvalid < FILL_W'(2)) || (pk[1] == CH_DQUOTE),
                    kind: KIND_QUOTED, empty: 1'b0, line: line_next};
          em_cnt = 3'd1;
          open_next = 1'b1;
        end
      end
      MODE_WORD: begin
        em[0] = '{tok_char: c, first: 1'b0, last: ends, kind: KIND_WORD,
                  empty: 1'b0, line: line_next};
        em_cnt = 3'd1;
        if (ends) begin
          mode_next = MODE_BETWEEN;
          open_next = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_BETWEEN;
        if (is_ws(c)) begin
          em_cnt = 3'd0;
        end else if ((c == CH_SLASH) && (pk[1] == CH_SLASH)) begin
          // texture comment tokens are kept, plain comments vanish
          if ((pk[2] == CH_T) && (pk[3] == CH_X) &&
              ((pk[4] == CH_ONE) || (pk[4] == CH_TWO))) begin
            for (int k = 0; k < ARRIVE_MAX; k++) begin
              em[k] = '{tok_char: pk[k], first: (k == 0), last: (k == ARRIVE_MAX - 1),
                        kind: KIND_TEXTURE, empty: 1'b0, line: line_next};
            end
            em_cnt = 3'(ARRIVE_MAX);
          end
          mode_next = MODE_COMMENT;
        end else if (c == CH_DQUOTE) begin
          mode_next = MODE_QUOTE;
          open_next = 1'b0;
        end else begin
          em[0] = '{tok_char: c, first: 1'b1, last: ends,
                    kind: (ends && is_punct(c)) ? KIND_PUNCT : KIND_WORD,
                    empty: 1'b0, line: line_next};
          em_cnt = 3'd1;
          if (!ends) begin
            mode_next = MODE_WORD;
            open_next = 1'b1;
          end
        end
      end
    endcase

    // the end-of-file drain shares one cap on characters per transaction
    allowed = MAX_RESULTS - ((state == ST_DRAIN) ? emitted : 4'd0);
    if (!arrive) begin
      wr_n = 4'd0;
    end else if ({1'b0, em_cnt} < allowed) begin
      wr_n = {1'b0, em_cnt};
    end else begin
      wr_n = allowed;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ARRIVE_MAX; k++) begin
      if (4'(k) < wr_n) begin
        queue[wr_ptr + QPTR_W'(k)] <= em[k];
      end
    end
    if (rst) begin
      state       <= ST_RUN;
      scan_mode   <= MODE_BETWEEN;
      token_open  <= 1'b0;
      line_count  <= 24'd1;
      fill        <= '0;
      drain_first <= 1'b0;
      emitted     <= 4'd0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        win[i] <= 8'h00;
      end
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(wr_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(wr_n) - QCNT_W'(pop);
      if (arrive) begin
        scan_mode  <= mode_next;
        token_open <= open_next;
        line_count <= line_next;
      end
      unique case (state)
        ST_RUN: begin
          if (run_acc) begin
            if (end_of_file) begin
              state       <= ST_DRAIN;
              drain_first <= (fill != '0) && !fill_full;
              emitted     <= 4'd0;
            end else begin
              win <= w_new;
              if (!fill_full) begin
                fill <= fill + FILL_W'(1);
              end
            end
          end
        end
        ST_DRAIN: begin
          if (drain_step) begin
            emitted <= emitted + wr_n;
            if (drain_first) begin
              drain_first <= 1'b0;
            end else if (fill > FILL_W'(1)) begin
              win  <= shifted;
              fill <= fill - FILL_W'(1);
            end else begin
              // window empty: back to the state of a fresh file
              state      <= ST_RUN;
              scan_mode  <= MODE_BETWEEN;
              token_open <= 1'b0;
              line_count <= 24'd1;
              fill       <= '0;
              for (int i = 0; i < WINDOW_BYTES; i++) begin
                win[i] <= 8'h00;
              end
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // queue head drives the token channel
  assign token_char   = queue[rd_ptr].tok_char;
  assign token_first  = queue[rd_ptr].first;
  assign token_last   = queue[rd_ptr].last;
  assign token_kind   = queue[rd_ptr].kind;
  assign empty_quoted = queue[rd_ptr].empty;
  assign line_number  = queue[rd_ptr].line;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  a_empty_token: assert property (@(posedge clk) disable iff (rst)
    (token_valid && empty_quoted) |->
      (token_first && token_last && token_char == 8'h00 && token_kind == KIND_QUOTED))
    else $error("malformed empty quoted token");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != 24'd0)
    else $error("line counter reached zero");

  a_eof_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && run_acc && end_of_file) |=> (state == ST_DRAIN))
    else $error("end of file did not start the drain");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    emitted <= MAX_RESULTS)
    else $error("too many characters for one transaction");
`endif

endmodule

// ===== tb/map_file_tokenizer_tb.sv =====
`timescale 1ns / 1ps

module map_file_tokenizer_tb;
  import mft_pkg::*;

  localparam int WIN          = 5;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 32;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 210;

  // scanner modes of the predictor
  typedef enum logic [1:0] {
    SCAN_GAP,
    SCAN_COMMENT,
    SCAN_WORD,
    SCAN_QUOTE
  } scan_e;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        end_of_file;
  logic        token_valid;
  logic        token_stall;
  logic [7:0]  token_char;
  logic        token_first;
  logic        token_last;
  logic [1:0]  token_kind;
  logic        empty_quoted;
  logic [23:0] line_number;

  // predictor state: look-ahead window, fill, mode, open token, line
  logic [7:0]  win_q [8];
  int          win_cnt;
  scan_e       scan_st;
  logic        tok_open;
  logic [23:0] cur_line;
  int          step_emits;

  // characters still owed by the block, oldest first
  tok_t        expected_tokens [$];
  tok_t        want;
  tok_t        got;

  int          mismatch_count = 0;
  int          transactions_sent = 0;
  int unsigned cycle_count = 0;
  // no idling on either side while set, save a requested hold-off
  logic        quiet;
  // long receiver hold-offs asked for by the tests and served by the sink
  int          holds_asked = 0;
  int          holds_done = 0;

  map_file_tokenizer #(
    .WINDOW_BYTES(WIN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_char  (token_char),
    .token_first (token_first),
    .token_last  (token_last),
    .token_kind  (token_kind),
    .empty_quoted(empty_quoted),
    .line_number (line_number)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  // control bytes, space and the upper half all separate words
  function automatic logic blank_byte(logic [7:0] c);
    return (c <= 8'h20) || (c >= 8'h80);
  endfunction

  // characters that end a word; followed by a separator one stands alone as a punct token
  function automatic logic mark_byte(logic [7:0] c);
    case (c) inside
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_COLON: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // window byte i, zero past the valid bytes
  function automatic logic [7:0] look(int i, int nvalid);
    return (i < nvalid) ? win_q[i] : 8'h00;
  endfunction

  task automatic clear_scanner();
    for (int i = 0; i < 8; i++) win_q[i] = 8'h00;
    win_cnt  = 0;
    scan_st  = SCAN_GAP;
    tok_open = 1'b0;
    cur_line = 24'd1;
  endtask

  task automatic advance_window();
    for (int i = 0; i < 7; i++) win_q[i] = win_q[i + 1];
    win_q[7] = 8'h00;
  endtask

  // one expected character, tagged with the current line
  task automatic push_token(logic [7:0] ch, logic first, logic last, logic [1:0] kind,
                            logic empty);
    tok_t t;
    if (step_emits < MAX_RESULTS) begin
      t.tok_char = ch;
      t.first    = first;
      t.last     = last;
      t.kind     = kind;
      t.empty    = empty;
      t.line     = cur_line;
      expected_tokens.push_back(t);
      step_emits++;
    end
  endtask

  // the oldest window byte is examined with nvalid bytes valid
  task automatic scan_arrival(int nvalid);
    logic [7:0] c;
    logic [7:0] nx;
    logic [7:0] d;
    logic       ends;
    c  = win_q[0];
    if (c == CH_LF && cur_line < LINE_MAX) cur_line++;
    nx = look(1, nvalid);
    // the next byte decides whether a word ends here
    ends = (nvalid < 2) || blank_byte(nx) || mark_byte(nx);
    case (scan_st)
      SCAN_COMMENT: begin
        if (c == CH_LF) scan_st = SCAN_GAP;
      end
      SCAN_QUOTE: begin
        if (c == CH_DQUOTE) begin
          // closing quote with nothing inside gives a flagged empty token
          if (!tok_open) push_token(8'h00, 1'b1, 1'b1, KIND_QUOTED, 1'b1);
          tok_open = 1'b0;
          scan_st  = SCAN_GAP;
        end else begin
          push_token(c, !tok_open, (nvalid < 2) || (nx == CH_DQUOTE), KIND_QUOTED, 1'b0);
          tok_open = 1'b1;
        end
      end
      SCAN_WORD: begin
        push_token(c, 1'b0, ends, KIND_WORD, 1'b0);
        if (ends) begin
          scan_st  = SCAN_GAP;
          tok_open = 1'b0;
        end
      end
      default: begin
        scan_st = SCAN_GAP;
        if (!blank_byte(c)) begin
          if (c == CH_SLASH && nx == CH_SLASH) begin
            // texture comments are emitted whole when the first slash arrives
            d = look(4, nvalid);
            if (look(2, nvalid) == CH_T && look(3, nvalid) == CH_X &&
                (d == CH_ONE || d == CH_TWO)) begin
              push_token(CH_SLASH, 1'b1, 1'b0, KIND_TEXTURE, 1'b0);
              push_token(CH_SLASH, 1'b0, 1'b0, KIND_TEXTURE, 1'b0);
              push_token(CH_T, 1'b0, 1'b0, KIND_TEXTURE, 1'b0);
              push_token(CH_X, 1'b0, 1'b0, KIND_TEXTURE, 1'b0);
              push_token(d, 1'b0, 1'b1, KIND_TEXTURE, 1'b0);
            end
            scan_st = SCAN_COMMENT;
          end else if (c == CH_DQUOTE) begin
            scan_st  = SCAN_QUOTE;
            tok_open = 1'b0;
          end else begin
            // a lone punctuation character is kind punct, any other lone character a word; else it opens a word
            push_token(c, 1'b1, ends, (ends && mark_byte(c)) ? KIND_PUNCT : KIND_WORD, 1'b0);
            if (!ends) begin
              scan_st  = SCAN_WORD;
              tok_open = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  // expected characters of one accepted byte or end transaction
  task automatic predict_transaction(logic [7:0] b, logic eof);
    step_emits = 0;
    if (!eof) begin
      if (win_cnt < WIN) begin
        win_q[win_cnt] = b;
        win_cnt++;
        if (win_cnt == WIN) scan_arrival(win_cnt);
      end else begin
        advance_window();
        win_q[WIN - 1] = b;
        scan_arrival(win_cnt);
      end
    end else begin
      // drain the window, then back to the state after reset
      if (win_cnt > 0 && win_cnt < WIN) scan_arrival(win_cnt);
      while (win_cnt > 1) begin
        advance_window();
        win_cnt--;
        scan_arrival(win_cnt);
      end
      clear_scanner();
    end
  endtask

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  // idle lengths: mostly none or short, now and then long
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one byte transaction; valid stays high afterwards until the next negedge
  task automatic send_item(logic [7:0] b, logic eof);
    int n;
    n = quiet ? 0 : gap_length();
    repeat (n) begin
      @(negedge clk);
      byte_valid = 1'b0;
    end
    @(negedge clk);
    byte_valid  = 1'b1;
    data_byte   = b;
    end_of_file = eof;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_transaction(b, eof);
    transactions_sent++;
  endtask

  // end of file; the byte is don't-care, so it is random
  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // sender holds off until the block has delivered everything owed
  task automatic wait_for_results();
    @(negedge clk);
    byte_valid = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_SQUOTE;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_LF;
      2: return 8'h09;
      3: return 8'h00;
      4: return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range(8'h01, 8'h20));
    endcase
  endfunction

  function automatic logic [7:0] pick_printable();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // a short map-like file of random pieces, mostly closed by an end transaction
  task automatic send_random_file();
    int pieces;
    int r;
    int n;
    pieces = $urandom_range(2, 10);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_item(pick_printable(), 1'b0);
      end else if (r < 42) begin
        send_item(pick_punct(), 1'b0);
      end else if (r < 58) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_item(pick_blank(), 1'b0);
      end else if (r < 72) begin
        // quoted string, any content, sometimes left open
        send_item(CH_DQUOTE, 1'b0);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 99) < 85) send_item(CH_DQUOTE, 1'b0);
      end else if (r < 80) begin
        send_text("//");
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_item(pick_printable(), 1'b0);
        send_item(CH_LF, 1'b0);
      end else if (r < 90) begin
        send_text("//TX");
        send_item($urandom_range(0, 1) ? CH_ONE : CH_TWO, 1'b0);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) send_item(pick_printable(), 1'b0);
        if ($urandom_range(0, 99) < 70) send_item(CH_LF, 1'b0);
      end else if (r < 95) begin
        // near misses of a texture comment
        send_text("//T");
        send_item(pick_printable(), 1'b0);
        send_item(8'($urandom_range(8'h30, 8'h39)), 1'b0);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 99) < 70) send_item(pick_blank(), 1'b0);
    end
    if ($urandom_range(0, 99) < 85) send_eof();
  endtask

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // punct opening a word, lone punct, byte extremes, word cut by the end
  task automatic test_words_and_punct();
    send_text("{a: )");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h21, 1'b0);
    send_eof();
  endtask

  // empty quoted string, then a string left open at the end
  task automatic test_quoted_strings();
    send_text("\"\"\"x");
    send_eof();
  endtask

  // texture comment with nothing after it, then a skipped comment and a line
  task automatic test_comments();
    send_text("//TX2");
    send_eof();
    send_text("//q\nk");
    send_eof();
  endtask

  // end on an empty window, and an opening quote as the last byte
  task automatic test_end_of_input();
    send_eof();
    send_text("a\"");
    send_eof();
  endtask

  task automatic test_random_files();
    int start;
    start = transactions_sent;
    while (transactions_sent - start < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      send_random_file();
    end
    quiet = 1'b0;
  endtask

  // receiver holds off long while bytes keep coming: the queue fills and
  // byte_stall has to rise
  task automatic test_back_pressure();
    quiet = 1'b1;
    holds_asked++;
    for (int i = 0; i < 48; i++) begin
      if (i % 4 == 3) send_item(CH_SPACE, 1'b0);
      else send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    end
    send_text("//TX1\n");
    send_eof();
    quiet = 1'b0;
  endtask

  // sender pauses mid-file until everything owed has come out
  task automatic test_sender_pause();
    send_text("key \"val\" ");
    wait_for_results();
    send_text("( x )\n");
    send_eof();
  endtask

  // ---------------------------------------------------------------
  // token sink: random stalls, quiet stretches, long hold-offs on request
  // ---------------------------------------------------------------
  initial begin : token_sink
    int free_left;
    int stall_left;
    free_left   = 0;
    stall_left  = 0;
    token_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done  = holds_asked;
        token_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        token_stall = 1'b0;
      end else if (quiet) begin
        token_stall = 1'b0;
      end else if (stall_left > 0) begin
        token_stall = 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        token_stall = 1'b0;
        free_left--;
      end else begin
        token_stall = 1'b0;
        free_left   = $urandom_range(0, 15);
        stall_left  = gap_length();
      end
    end
  end

  // ---------------------------------------------------------------
  // checker: each token transaction against the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      got.tok_char = token_char;
      got.first    = token_first;
      got.last     = token_last;
      got.kind     = token_kind;
      got.empty    = empty_quoted;
      got.line     = line_number;
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected token char %h first %b last %b kind %0d empty %b line %0d",
                   got.tok_char, got.first, got.last, got.kind, got.empty, got.line);
      end else begin
        want = expected_tokens.pop_front();
        if (got.tok_char !== want.tok_char || got.first !== want.first ||
            got.last !== want.last || got.kind !== want.kind ||
            got.empty !== want.empty || got.line !== want.line) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("token mismatch: expected char %h first %b last %b kind %0d empty %b line %0d",
                     want.tok_char, want.first, want.last, want.kind, want.empty, want.line);
            $display("                got      char %h first %b last %b kind %0d empty %b line %0d",
                     got.tok_char, got.first, got.last, got.kind, got.empty, got.line);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("map_file_tokenizer_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    byte_valid  = 1'b0;
    data_byte   = 8'h00;
    end_of_file = 1'b0;
    quiet       = 1'b0;
    clear_scanner();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_words_and_punct();
    test_quoted_strings();
    test_comments();
    test_end_of_input();
    test_random_files();
    test_back_pressure();
    test_sender_pause();

    // everything owed has to arrive, then nothing more may show up
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("map_file_tokenizer_tb passed");
    end else begin
      $display("map_file_tokenizer_tb failed");
    end
    $finish;
  end

endmodule
